// ===== sv/height_glitch_filter_vertical_speed_defines.svh =====
// assertion macros for the height glitch filter block
`ifndef HEIGHT_GLITCH_FILTER_VERTICAL_SPEED_DEFINES_SVH
`define HEIGHT_GLITCH_FILTER_VERTICAL_SPEED_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while rst_n is low
`define HGFVS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hgfvs assertion failed");
// next-cycle implication, sampled on clk, off while rst_n is low
`define HGFVS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hgfvs assertion failed");
`else
`define HGFVS_ASSERT_SAME(label, ante, cons)
`define HGFVS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/hgfvs_pkg.sv =====
// shared types and constants of the height glitch filter block
`default_nettype none

package hgfvs_pkg;

  localparam int HEIGHT_W = 16;
  localparam int TIME_W   = 32;
  localparam int RATE_W   = 10;
  localparam int SPEED_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd2;

  localparam logic [HEIGHT_W-1:0] JUMP_LIMIT_RST  = 16'd50;
  localparam logic [TIME_W-1:0]   HOLD_TIME_RST   = 32'd100000;
  localparam logic [RATE_W-1:0]   SAMPLE_RATE_RST = 10'd25;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_WALK  = 6'b000010,
    ST_SCALE = 6'b000100,
    ST_ABS   = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_EMIT  = 6'b100000
  } hgfvs_state_t;

endpackage

`default_nettype wire

// ===== sv/height_glitch_filter_vertical_speed.sv =====
// Height glitch filter with vertical speed estimate. Each item is a height
// sample (mm), a wrapping microsecond timestamp and a measured flag, and gives
// one result. A sample that jumps more than jump_limit_mm from the last
// accepted height less than hold_time_us after it is rejected and the last
// height is held. On measured samples the output height enters a ring of
// WINDOW entries and the speed becomes the least-squares slope over the ring
// (oldest at x = 0) times sample_rate_hz, truncated toward zero and saturated.
// An unmeasured item goes from the accept straight to the emit step, and its
// result is valid by the time the next item is taken. A measured item runs
// through the walk, scale, magnitude, divide and emit steps, its result valid
// before the next accept: one multiply-accumulate per window entry on the
// shared multiplier, one multiply by the rate, the magnitude, then the
// quotient by the constant regression denominator as a multiply by its
// reciprocal on the same multiplier, one 16-bit slice of the magnitude per
// cycle (NCH = 2 slices at WINDOW = 3), and the emit step. While the
// previous result still waits on out_stall, emit holds. The input stalls
// while an item is in work; a finished result waits in the output register
// while the next item is taken. cfg_ready is always high; write registers
// only while the block is idle.
`default_nettype none
`include "height_glitch_filter_vertical_speed_defines.svh"

module height_glitch_filter_vertical_speed
  import hgfvs_pkg::*;
#(
  parameter int WINDOW = 3
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input items
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [HEIGHT_W-1:0]         in_height_mm,
  input  wire logic [TIME_W-1:0]           in_time_us,
  input  wire logic                        in_height_measured,
  // result items
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [HEIGHT_W-1:0]              out_height_out_mm,
  output logic signed [SPEED_W-1:0]        out_vertical_speed,
  output logic                             out_sample_rejected,
  // register writes
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam int SX     = WINDOW * (WINDOW - 1) / 2;
  localparam int DEN    = WINDOW * WINDOW * (WINDOW * WINDOW - 1) / 12;
  localparam int PW     = $clog2(WINDOW);
  localparam int CW     = $clog2(SX + 1) + 1;
  localparam int ACC_W  = HEIGHT_W + CW + PW + 1;
  localparam int MB_W   = HEIGHT_W + 1;
  localparam int PROD_W = ACC_W + RATE_W;
  // reciprocal of the denominator, exact for any PROD_W-bit magnitude
  localparam int SHR    = PROD_W + $clog2(DEN);
  localparam int REC_W  = PROD_W + 1;
  localparam int A_W    = REC_W + 1;
  localparam int MUL_W  = A_W + MB_W;
  localparam int CH_W   = MB_W - 1;
  localparam int NCH    = (PROD_W + CH_W - 1) / CH_W;
  localparam int MAG_W  = NCH * CH_W;
  localparam int RACC_W = PROD_W + REC_W;
  localparam int DCNT_W = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int EXT_W  = (PROD_W > 33) ? PROD_W : 33;

  localparam logic [63:0]          REC64     = ((64'd1 << SHR) + 64'(DEN) - 64'd1) / 64'(DEN);
  localparam logic [REC_W-1:0]     REC       = REC_W'(REC64);
  localparam logic signed [CW-1:0] COEF0     = CW'(-SX);
  localparam logic signed [CW-1:0] COEF_STEP = CW'(WINDOW);
  localparam logic [PW-1:0]        PTR_LAST  = PW'(WINDOW - 1);
  localparam logic [EXT_W-1:0]     POS_LIM   = EXT_W'(33'h0_7FFF_FFFF);
  localparam logic [EXT_W-1:0]     NEG_LIM   = EXT_W'(33'h0_8000_0000);

  hgfvs_state_t state_r, state_nxt;

  logic [HEIGHT_W-1:0] jump_r;
  logic [TIME_W-1:0]   hold_r;
  logic [RATE_W-1:0]   rate_r;

  logic                primed_r;
  logic [HEIGHT_W-1:0] last_h_r;
  logic [TIME_W-1:0]   last_t_r;
  logic [HEIGHT_W-1:0] win_r [WINDOW];
  logic [PW-1:0]       wp_r;
  logic signed [SPEED_W-1:0] speed_r;

  logic [HEIGHT_W-1:0] hout_r;
  logic                rej_r;
  logic                meas_r;
  logic [PW-1:0]       rd_r;
  logic [PW-1:0]       cnt_r;
  logic signed [CW-1:0]    coef_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                neg_r;
  logic [MAG_W-1:0]    mag_sh_r;
  logic [RACC_W-1:0]   racc_r;
  logic [DCNT_W-1:0]   dcnt_r;
  logic                out_valid_r;

  // glitch test on the incoming item
  logic                in_acc;
  logic [HEIGHT_W-1:0] lh;
  logic [TIME_W-1:0]   lt;
  logic [HEIGHT_W-1:0] diff;
  logic [TIME_W-1:0]   elapsed;
  logic                rej;
  logic [HEIGHT_W-1:0] hout;
  logic [PW-1:0]       wp_adv;

  assign in_acc  = in_valid && !in_stall;
  assign lh      = primed_r ? last_h_r : in_height_mm;
  assign lt      = primed_r ? last_t_r : in_time_us;
  assign diff    = (in_height_mm >= lh) ? (in_height_mm - lh) : (lh - in_height_mm);
  assign elapsed = in_time_us - lt;
  assign rej     = (diff > jump_r) && (elapsed < hold_r);
  assign hout    = rej ? lh : in_height_mm;
  assign wp_adv  = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;

  // shared multiplier: coefficient times entry while walking, sum times rate,
  // then reciprocal times one magnitude slice
  logic signed [A_W-1:0]   mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [MUL_W-1:0] mul_p;

  always_comb begin
    if (state_r == ST_WALK) begin
      mul_a = A_W'(coef_r);
      mul_b = MB_W'(win_r[rd_r]);
    end else if (state_r == ST_SCALE) begin
      mul_a = A_W'(acc_r);
      mul_b = MB_W'(rate_r);
    end else begin
      mul_a = A_W'(REC);
      mul_b = MB_W'(mag_sh_r[MAG_W-1 -: CH_W]);
    end
  end

  assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

  // signed, saturated quotient
  logic [EXT_W-1:0]          mag;
  logic signed [SPEED_W-1:0] sat_speed;

  assign mag = EXT_W'(racc_r >> SHR);

  always_comb begin
    if (neg_r) begin
      sat_speed = (mag > NEG_LIM) ? 32'sh8000_0000 : SPEED_W'(~mag[31:0] + 32'd1);
    end else begin
      sat_speed = (mag > POS_LIM) ? 32'sh7FFF_FFFF : SPEED_W'(mag[31:0]);
    end
  end

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = in_height_measured ? ST_WALK : ST_EMIT;
      end
      ST_WALK: begin
        if (cnt_r == PTR_LAST) state_nxt = ST_SCALE;
      end
      ST_SCALE: state_nxt = ST_ABS;
      ST_ABS:   state_nxt = ST_DIV;
      ST_DIV: begin
        if (dcnt_r == '0) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      jump_r      <= JUMP_LIMIT_RST;
      hold_r      <= HOLD_TIME_RST;
      rate_r      <= SAMPLE_RATE_RST;
      primed_r    <= 1'b0;
      last_h_r    <= '0;
      last_t_r    <= '0;
      wp_r        <= '0;
      speed_r     <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_JUMP_LIMIT:  jump_r <= cfg_data[HEIGHT_W-1:0];
          CFG_HOLD_TIME:   hold_r <= cfg_data[TIME_W-1:0];
          CFG_SAMPLE_RATE: rate_r <= cfg_data[RATE_W-1:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        primed_r <= 1'b1;
        if (!rej) begin
          last_h_r <= in_height_mm;
          last_t_r <= in_time_us;
        end
        if (in_height_measured) begin
          win_r[wp_r] <= hout;
          wp_r        <= wp_adv;
        end
      end

      if (state_r == ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
        if (meas_r) speed_r <= sat_speed;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      hout_r <= hout;
      rej_r  <= rej;
      meas_r <= in_height_measured;
      rd_r   <= wp_adv;
      cnt_r  <= '0;
      coef_r <= COEF0;
      acc_r  <= '0;
    end

    if (state_r == ST_WALK) begin
      acc_r  <= acc_r + ACC_W'(mul_p);
      coef_r <= coef_r + COEF_STEP;
      rd_r   <= (rd_r == PTR_LAST) ? '0 : rd_r + 1'b1;
      cnt_r  <= cnt_r + 1'b1;
    end

    if (state_r == ST_SCALE) begin
      prod_r <= PROD_W'(mul_p);
    end

    if (state_r == ST_ABS) begin
      neg_r    <= prod_r[PROD_W-1];
      mag_sh_r <= prod_r[PROD_W-1] ? MAG_W'($unsigned(-prod_r)) : MAG_W'($unsigned(prod_r));
      racc_r   <= '0;
      dcnt_r   <= DCNT_W'(NCH - 1);
    end

    // top slice first, so the product builds up as shift and add
    if (state_r == ST_DIV) begin
      mag_sh_r <= mag_sh_r << CH_W;
      racc_r   <= (racc_r << CH_W) + RACC_W'(mul_p);
      dcnt_r   <= dcnt_r - 1'b1;
    end

    if (state_r == ST_EMIT && out_free) begin
      out_height_out_mm   <= hout_r;
      out_sample_rejected <= rej_r;
      out_vertical_speed  <= meas_r ? sat_speed : speed_r;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  // an accepted item always leaves idle
  `HGFVS_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_r != ST_IDLE)
  // a new result appears only out of the emit step
  `HGFVS_ASSERT_SAME(a_result_from_emit, $rose(out_valid_r), $past(state_r) == ST_EMIT)
  // the divider hands over to emit after its last slice
  `HGFVS_ASSERT_NEXT(a_div_done, (state_r == ST_DIV) && (dcnt_r == '0), state_r == ST_EMIT)
  // a rejected sample holds the last accepted height
  `HGFVS_ASSERT_SAME(a_reject_holds, in_acc && rej, hout == last_h_r)

endmodule

`default_nettype wire
